// ===== sv/sue_pkg.sv =====
// ----------------------------------------------------------------------------
// sue_pkg
// shared widths and codes for the strongest unique entry table
// ----------------------------------------------------------------------------
package sue_pkg;

    localparam int WORD_W     = 64;
    localparam int NAME_MAX_W = 4 * WORD_W;
    localparam int ADDR_W     = 48;
    localparam int STR_W      = 8;
    localparam int CHAN_W     = 8;
    localparam int SEC_W      = 32;
    localparam int LEN_W      = 8;
    localparam int IDX_W      = 8;
    localparam int CNT_OUT_W  = 5;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_REPORT = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [1:0] STAT_IGNORED   = 2'd2;

endpackage

// ===== sv/strongest_unique_entry_table.sv =====
// ----------------------------------------------------------------------------
// strongest_unique_entry_table
// table of scanned network records with clear, read, and report by match, append and weakest replacement
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | word
//  req      | in        | req_valid/req_stall  | func, name, address, strength, ...
//  rsp      | out       | rsp_valid/rsp_stall  | status, count, read entry
//
//  clear, bad read, ignored report: decode, response; good read: decode, read wait,
//  response; report: scan (skipped when empty) ends on a match, else decide, then response;
//  one entry compare per cycle through the record memory read port
//  req_stall is high from accept until the word moves to the output register
//  record memory has no reset; count and scan flag clear on rst_n
// ----------------------------------------------------------------------------
module strongest_unique_entry_table #(
    parameter int MAX_ENTRIES = 16,
    parameter int NAME_BYTES  = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [1:0]                       func,
    input  logic [sue_pkg::LEN_W-1:0]        name_len,
    input  logic [sue_pkg::WORD_W-1:0]       name_w0,
    input  logic [sue_pkg::WORD_W-1:0]       name_w1,
    input  logic [sue_pkg::WORD_W-1:0]       name_w2,
    input  logic [sue_pkg::WORD_W-1:0]       name_w3,
    input  logic [sue_pkg::ADDR_W-1:0]       station_addr,
    input  logic signed [sue_pkg::STR_W-1:0] strength,
    input  logic [sue_pkg::CHAN_W-1:0]       chan,
    input  logic [sue_pkg::SEC_W-1:0]        sec_code,
    input  logic [sue_pkg::IDX_W-1:0]        read_index,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [1:0]                       status,
    output logic [sue_pkg::CNT_OUT_W-1:0]    entry_count,
    output logic                             scan_started,
    output logic [sue_pkg::WORD_W-1:0]       out_name_w0,
    output logic [sue_pkg::WORD_W-1:0]       out_name_w1,
    output logic [sue_pkg::WORD_W-1:0]       out_name_w2,
    output logic [sue_pkg::WORD_W-1:0]       out_name_w3,
    output logic [sue_pkg::ADDR_W-1:0]       out_addr,
    output logic signed [sue_pkg::STR_W-1:0] out_strength,
    output logic [sue_pkg::CHAN_W-1:0]       out_chan,
    output logic [sue_pkg::SEC_W-1:0]        out_sec
);
    import sue_pkg::*;

    localparam int NAME_W = 8 * NAME_BYTES;
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int AW     = $clog2(MAX_ENTRIES);

    typedef struct packed {
        logic [NAME_W-1:0]       name;
        logic [ADDR_W-1:0]       addr;
        logic signed [STR_W-1:0] strength;
        logic [CHAN_W-1:0]       chan;
        logic [SEC_W-1:0]        sec;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DECIDE,
        ST_RDWAIT,
        ST_RESP
    } state_t;

    function automatic logic [NAME_W-1:0] norm_name(input logic [NAME_MAX_W-1:0] raw,
                                                    input logic [LEN_W-1:0] len);
        logic [NAME_BYTES-1:0] nz;
        logic [NAME_BYTES-1:0] low;
        logic [NAME_W-1:0]     res;
        res = '0;
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            nz[i] = |raw[8*i +: 8];
        end
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            low = {NAME_BYTES{1'b1}} >> (NAME_BYTES - 1 - i);
            if ((LEN_W'(i) < len) && (&(nz | ~low)))
            begin
                res[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return res;
    endfunction

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;
    logic   wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    entry_t wr_data;

    state_t state_reg, state_next;
    logic [1:0]              func_reg, func_next;
    logic                    empty_reg, empty_next;
    logic [NAME_W-1:0]       nm_reg, nm_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic signed [STR_W-1:0] str_reg, str_next;
    logic [CHAN_W-1:0]       chan_reg, chan_next;
    logic [SEC_W-1:0]        sec_reg, sec_next;
    logic [IDX_W-1:0]        ridx_reg, ridx_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    started_reg, started_next;
    logic [CW-1:0]           scan_idx_reg, scan_idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]           cmp_idx_reg, cmp_idx_next;
    logic signed [STR_W-1:0] min_str_reg, min_str_next;
    logic [AW-1:0]           min_idx_reg, min_idx_next;
    logic [1:0]              res_status_reg, res_status_next;
    entry_t                  res_entry_reg, res_entry_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic [1:0]              rsp_status_reg, rsp_status_next;
    logic [CW-1:0]           rsp_count_reg, rsp_count_next;
    logic                    rsp_started_reg, rsp_started_next;
    entry_t                  rsp_entry_reg, rsp_entry_next;

    logic                    issue;
    logic                    match;
    logic [NAME_MAX_W-1:0]   name_full;

    assign wr_data = '{name: nm_reg, addr: addr_reg, strength: str_reg,
                       chan: chan_reg, sec: sec_reg};
    assign issue   = (scan_idx_reg < count_reg);
    assign match   = (rd_data_reg.name == nm_reg) && (rd_data_reg.addr == addr_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        empty_next       = empty_reg;
        nm_next          = nm_reg;
        addr_next        = addr_reg;
        str_next         = str_reg;
        chan_next        = chan_reg;
        sec_next         = sec_reg;
        ridx_next        = ridx_reg;
        count_next       = count_reg;
        started_next     = started_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        cmp_idx_next     = cmp_idx_reg;
        min_str_next     = min_str_reg;
        min_idx_next     = min_idx_reg;
        res_status_next  = res_status_reg;
        res_entry_next   = res_entry_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_count_next   = rsp_count_reg;
        rsp_started_next = rsp_started_reg;
        rsp_entry_next   = rsp_entry_reg;
        wr_en            = 1'b0;
        wr_addr          = cmp_idx_reg;
        rd_addr          = scan_idx_reg[AW-1:0];

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = func;
                    empty_next = (name_len == '0);
                    nm_next    = norm_name({name_w3, name_w2, name_w1, name_w0}, name_len);
                    addr_next  = station_addr;
                    str_next   = strength;
                    chan_next  = chan;
                    sec_next   = sec_code;
                    ridx_next  = read_index;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                res_entry_next = '0;
                case (func_reg)
                    FUNC_CLEAR:
                    begin
                        count_next      = '0;
                        started_next    = 1'b1;
                        res_status_next = STAT_OK;
                        state_next      = ST_RESP;
                    end
                    FUNC_REPORT:
                    begin
                        if (!started_reg || empty_reg)
                        begin
                            res_status_next = STAT_IGNORED;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            scan_idx_next = '0;
                            cmp_vld_next  = 1'b0;
                            state_next    = (count_reg == '0) ? ST_DECIDE : ST_SCAN;
                        end
                    end
                    FUNC_READ:
                    begin
                        if (ridx_reg >= IDX_W'(count_reg))
                        begin
                            res_status_next = STAT_BAD_INDEX;
                            state_next      = ST_RESP;
                        end
                        else
                        begin
                            rd_addr    = ridx_reg[AW-1:0];
                            state_next = ST_RDWAIT;
                        end
                    end
                    default:
                    begin
                        res_status_next = STAT_IGNORED;
                        state_next      = ST_RESP;
                    end
                endcase
            end
            ST_SCAN:
            begin
                cmp_vld_next = issue;
                cmp_idx_next = scan_idx_reg[AW-1:0];
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (match)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = cmp_idx_reg;
                        res_status_next = STAT_OK;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        if ((cmp_idx_reg == '0) ||
                            ($signed(rd_data_reg.strength) < $signed(min_str_reg)))
                        begin
                            min_str_next = rd_data_reg.strength;
                            min_idx_next = cmp_idx_reg;
                        end
                        if (CW'(cmp_idx_reg) + CW'(1) == count_reg)
                        begin
                            state_next = ST_DECIDE;
                        end
                    end
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_RESP;
                if (count_reg < CW'(MAX_ENTRIES))
                begin
                    wr_en           = 1'b1;
                    wr_addr         = count_reg[AW-1:0];
                    count_next      = count_reg + CW'(1);
                    res_status_next = STAT_OK;
                end
                else if ($signed(str_reg) > $signed(min_str_reg))
                begin
                    wr_en           = 1'b1;
                    wr_addr         = min_idx_reg;
                    res_status_next = STAT_OK;
                end
                else
                begin
                    res_status_next = STAT_IGNORED;
                end
            end
            ST_RDWAIT:
            begin
                res_entry_next  = rd_data_reg;
                res_status_next = STAT_OK;
                state_next      = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = res_status_reg;
                    rsp_count_next   = count_reg;
                    rsp_started_next = started_reg;
                    rsp_entry_next   = res_entry_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            func_reg        <= '0;
            empty_reg       <= 1'b0;
            nm_reg          <= '0;
            addr_reg        <= '0;
            str_reg         <= '0;
            chan_reg        <= '0;
            sec_reg         <= '0;
            ridx_reg        <= '0;
            count_reg       <= '0;
            started_reg     <= 1'b0;
            scan_idx_reg    <= '0;
            cmp_vld_reg     <= 1'b0;
            cmp_idx_reg     <= '0;
            min_str_reg     <= '0;
            min_idx_reg     <= '0;
            res_status_reg  <= '0;
            res_entry_reg   <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_status_reg  <= '0;
            rsp_count_reg   <= '0;
            rsp_started_reg <= 1'b0;
            rsp_entry_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            func_reg        <= func_next;
            empty_reg       <= empty_next;
            nm_reg          <= nm_next;
            addr_reg        <= addr_next;
            str_reg         <= str_next;
            chan_reg        <= chan_next;
            sec_reg         <= sec_next;
            ridx_reg        <= ridx_next;
            count_reg       <= count_next;
            started_reg     <= started_next;
            scan_idx_reg    <= scan_idx_next;
            cmp_vld_reg     <= cmp_vld_next;
            cmp_idx_reg     <= cmp_idx_next;
            min_str_reg     <= min_str_next;
            min_idx_reg     <= min_idx_next;
            res_status_reg  <= res_status_next;
            res_entry_reg   <= res_entry_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_status_reg  <= rsp_status_next;
            rsp_count_reg   <= rsp_count_next;
            rsp_started_reg <= rsp_started_next;
            rsp_entry_reg   <= rsp_entry_next;
        end
    end

    assign name_full    = NAME_MAX_W'(rsp_entry_reg.name);
    assign req_stall    = (state_reg != ST_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign status       = rsp_status_reg;
    assign entry_count  = CNT_OUT_W'(rsp_count_reg);
    assign scan_started = rsp_started_reg;
    assign out_name_w0  = name_full[0*WORD_W +: WORD_W];
    assign out_name_w1  = name_full[1*WORD_W +: WORD_W];
    assign out_name_w2  = name_full[2*WORD_W +: WORD_W];
    assign out_name_w3  = name_full[3*WORD_W +: WORD_W];
    assign out_addr     = rsp_entry_reg.addr;
    assign out_strength = rsp_entry_reg.strength;
    assign out_chan     = rsp_entry_reg.chan;
    assign out_sec      = rsp_entry_reg.sec;

endmodule

// ===== sv/sue_chk.sv =====
// ----------------------------------------------------------------------------
// sue_chk
// port-level checks for the strongest unique entry table
// ----------------------------------------------------------------------------
module sue_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_stall,
    input logic                             rsp_valid,
    input logic                             rsp_stall,
    input logic [1:0]                       status,
    input logic [sue_pkg::CNT_OUT_W-1:0]    entry_count,
    input logic                             scan_started,
    input logic [sue_pkg::WORD_W-1:0]       out_name_w0,
    input logic [sue_pkg::ADDR_W-1:0]       out_addr,
    input logic [sue_pkg::SEC_W-1:0]        out_sec
);
    import sue_pkg::*;

    // response word holds while stalled
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(entry_count))
        else $error("response word changed while stalled");

    // an accepted request keeps the block busy the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request side not stalled after accept");

    // only a good read carries entry data
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != STAT_OK) |->
            (out_name_w0 == '0) && (out_addr == '0) && (out_sec == '0))
        else $error("entry data on a response that is not a good read");

    // nothing succeeds before the first clear
    a_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !scan_started |-> (status != STAT_OK) && (entry_count == '0))
        else $error("success or entries before any clear");

endmodule

bind strongest_unique_entry_table sue_chk u_sue_chk (.*);
